@@ design/ssaq_pkg.sv @@
// Shared types, constants and codes of the service slot admission queue.
package ssaq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int SLOTS_W     = 5;
    localparam int POS_W       = 5;
    localparam int CMP_W       = (LEN_W > SLOTS_W) ? LEN_W : SLOTS_W;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_IDX_SLOTS = 1'b0;

    localparam logic KIND_SERVE = 1'b0;
    localparam logic KIND_STOP  = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] client_id;
    } in_item_t;

    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] position;
        logic             was_present;
        logic             overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic             scan_done;
        logic             out_free;
        logic [LEN_W-1:0] queue_len;
    } dp_status_t;

endpackage

@@ design/ssaq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ssaq_ctrl.sv @@
// Controller state machine: sequences accept, list scan and result commit.
module ssaq_ctrl
    import ssaq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dp_status_t  status,
    output dp_cmd_t     cmd,
    output ctrl_state_t state
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

@@ design/ssaq_dp.sv @@
// Datapath: id store, scan counters, compaction, append and result register.
module ssaq_dp
    import ssaq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  in_item_t           in_data,
    input  logic [SLOTS_W-1:0] service_slots,
    output out_item_t          out_data,
    output logic               out_valid,
    input  logic               out_stall
);

    logic             kind_reg;
    logic [ID_W-1:0]  id_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] scan_idx_reg, scan_idx_next;
    logic [LEN_W-1:0] kept_reg, kept_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg, rd_vld_next;
    logic             hit_reg, hit_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             serve_hit;
    logic             issue;
    logic             cmp_en;
    logic             match;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ID_W-1:0]  ram_wdata;
    logic [ID_W-1:0]  rd_data;
    logic             has_room;
    logic [LEN_W-1:0] fin_pos;
    logic [CMP_W-1:0] fin_pos_wide;
    logic             out_free;

    ssaq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ids (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        serve_hit = hit_reg && (kind_reg == KIND_SERVE);
        issue     = cmd.scan && !serve_hit && (scan_idx_reg < len_reg);
        cmp_en    = cmd.scan && rd_vld_reg && !serve_hit;
        match     = (rd_data == id_reg);
        has_room  = (len_reg < LEN_W'(QUEUE_DEPTH));
        out_free  = !out_valid_reg || !out_stall;

        status.scan_done = serve_hit || ((scan_idx_reg == len_reg) && !rd_vld_reg);
        status.out_free  = out_free;
        status.queue_len = len_reg;

        len_next       = len_reg;
        scan_idx_next  = scan_idx_reg;
        kept_next      = kept_reg;
        rd_vld_next    = issue;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = kept_reg[IDX_W-1:0];
        ram_wdata = rd_data;

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + LEN_W'(1);
        end

        if (cmp_en)
        begin
            if (match)
            begin
                hit_next = 1'b1;
                pos_next = LEN_W'(rd_idx_reg) + LEN_W'(1);
            end
            else if (kind_reg == KIND_STOP)
            begin
                // Entries after the removed id move up by one place.
                ram_we    = 1'b1;
                kept_next = kept_reg + LEN_W'(1);
            end
        end

        fin_pos = '0;
        if (kind_reg == KIND_SERVE)
        begin
            if (hit_reg)
            begin
                fin_pos = pos_reg;
            end
            else if (has_room)
            begin
                fin_pos = len_reg + LEN_W'(1);
            end
        end
        fin_pos_wide = CMP_W'(fin_pos);

        if (cmd.finish)
        begin
            out_valid_next       = 1'b1;
            out_next.position    = fin_pos_wide[POS_W-1:0];
            out_next.was_present = hit_reg;
            out_next.granted     = (fin_pos != '0) &&
                                   (fin_pos_wide <= CMP_W'(service_slots));
            out_next.overflow    = (kind_reg == KIND_SERVE) && !hit_reg && !has_room;
            if (kind_reg == KIND_STOP)
            begin
                len_next = kept_reg;
            end
            else if (!hit_reg && has_room)
            begin
                ram_we    = 1'b1;
                ram_waddr = len_reg[IDX_W-1:0];
                ram_wdata = id_reg;
                len_next  = len_reg + LEN_W'(1);
            end
        end

        if (cmd.start)
        begin
            scan_idx_next = '0;
            kept_next     = '0;
            hit_next      = 1'b0;
            rd_vld_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            scan_idx_reg  <= '0;
            kept_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            scan_idx_reg  <= scan_idx_next;
            kept_reg      <= kept_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= in_data.kind;
            id_reg   <= in_data.client_id;
        end
        rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        pos_reg    <= pos_next;
        out_reg    <= out_next;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ design/service_slot_admission_queue_core.sv @@
// Top level of the service slot admission queue: APB register, controller and datapath.
//
//  Channel   Direction  Handshake                      Payload
//  in        sink       in_valid / in_stall            in_data (kind, client_id)
//  out       source     out_valid / out_stall          out_data (granted, position,
//                                                        was_present, overflow)
//  config    APB slave  psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item holds the block through accept, one RAM read per stored id, a compare of the
// last registered read, a step that sees the scan end, and commit, which waits while the
// output register holds a stalled result. A serve that finds its id ends the scan early.
// Reset clears the queue length, the controller and the output valid; ids need no reset.
// A held result does not block the next acceptance, only its commit into the output register.
module service_slot_admission_queue_core
    import ssaq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SLOTS_W-1:0] slots_reg, slots_next;
    logic               reg_idx;
    dp_cmd_t            cmd;
    dp_status_t         status;
    ctrl_state_t        state;

    // Registers sit on 4-byte boundaries; bit 2 selects the register index.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        slots_next = slots_reg;
        if (psel && penable && pwrite && (reg_idx == REG_IDX_SLOTS))
        begin
            slots_next = pwdata[SLOTS_W-1:0];
        end
        prdata = '0;
        if (reg_idx == REG_IDX_SLOTS)
        begin
            prdata = APB_DATA_W'(slots_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else
        begin
            slots_reg <= slots_next;
        end
    end

    // The controller decides when to accept, scan and commit.
    ssaq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // The datapath holds the id list, walks it and builds the result item.
    ssaq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_data       (in_data),
        .service_slots (slots_reg),
        .out_data      (out_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.queue_len <= LEN_W'(QUEUE_DEPTH))
        else $error("queue length exceeds the queue depth");

    a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |->
            !out_data.granted && (out_data.position == '0) && !out_data.was_present)
        else $error("overflow item carries a grant, position or presence");

    a_grant_needs_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.granted |-> (out_data.position != '0))
        else $error("granted item without a queue position");

    a_commit_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (state == ST_FINISH) && status.out_free)
        else $error("result committed outside the finish state or into a full register");

    a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
        (status.queue_len != $past(status.queue_len)) |-> $past(cmd.finish))
        else $error("queue length changed without a commit");
`endif

endmodule
